@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/maf_pkg.sv @@
package maf_pkg;

  // Default build of the filter.
  localparam int WINDOW_MAX_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int WL_W    = 9;

  localparam logic [WL_W-1:0] WL_RESET = 9'd8;

  // Register word indexes (byte address divided by four).
  localparam logic [PADDR_W-3:0] REG_WINDOW_LENGTH = 1'b0;

  // Input actions.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

endpackage

@@ rtl/moving_average_filter_unit.sv @@
// Moving average over the last window_length samples.
// Input channel: in_valid_i / in_stall_o with action_i and sample_i. An item
// with action sample adds the sample to the window and yields one average;
// an item with action clear empties the window and yields nothing.
// Output channel: out_valid_o / out_stall_i with average_o, the mean of the
// samples held, truncated toward zero.
// After acceptance a sample passes through the states READ, SUM, DIV and OUT;
// the bit-serial divider, one quotient bit per cycle over the SUM_W-bit sum,
// works in DIV, and the result is loaded into the output register from OUT.
// in_stall_o stays high from acceptance until the result is loaded, so one
// sample is in work at a time and the next item waits for it.
// A clear does not stall the input.
// The output register holds a finished average while out_stall_i is high; the
// next sample is still taken and computed, and waits for the register to free.
// Reset empties the window, sets window_length to 8 and drops any result.
// Writing window_length (byte address 0) also empties the window.
module moving_average_filter_unit #(
  parameter int WINDOW_MAX  = maf_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] average_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [maf_pkg::PADDR_W-1:0] paddr,
  input  logic [maf_pkg::PDATA_W-1:0] pwdata,
  output logic [maf_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  import maf_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_MAX);
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = SAMPLE_BITS + IDX_W;
  localparam int EXT_W = SUM_W - SAMPLE_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [WL_W-1:0]        wl_q;
  logic [IDX_W-1:0]       widx_q;
  logic [CNT_W-1:0]       count_q;
  logic [SUM_W-1:0]       sum_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] average_q;

  logic                   cfg_wr;
  logic                   in_acc;
  logic                   out_free;
  logic [CNT_W-1:0]       win_n;
  logic [IDX_W-1:0]       slot;
  logic [CNT_W-1:0]       slot_inc;
  logic [IDX_W-1:0]       slot_next;
  logic                   full;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SUM_W-1:0]       sum_d;
  logic [CNT_W-1:0]       divisor;
  logic                   div_start;
  logic                   div_done;
  logic [SUM_W-1:0]       quotient;

  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[PADDR_W-1:2] == REG_WINDOW_LENGTH);
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_WINDOW_LENGTH) ? PDATA_W'(wl_q) : '0;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // A zero length acts as one; lengths past the ring saturate.
  always_comb begin
    if (wl_q == '0) begin
      win_n = CNT_W'(1);
    end else if (32'(wl_q) > 32'(WINDOW_MAX)) begin
      win_n = CNT_W'(WINDOW_MAX);
    end else begin
      win_n = CNT_W'(wl_q);
    end
  end

  assign slot      = (CNT_W'(widx_q) >= win_n) ? '0 : widx_q;
  assign slot_inc  = CNT_W'(slot) + 1'b1;
  assign slot_next = (slot_inc >= win_n) ? '0 : IDX_W'(slot_inc);
  assign full      = count_q >= win_n;

  // Once full, the oldest sample leaves the sum as the new one enters.
  assign sum_d = sum_q + {{EXT_W{sample_q[SAMPLE_BITS-1]}}, sample_q}
                 - (full ? {{EXT_W{old_sample[SAMPLE_BITS-1]}}, old_sample} : '0);
  assign divisor   = full ? win_n : count_q + 1'b1;
  assign div_start = (state_q == S_SUM);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (action_i == ACT_SAMPLE)) begin
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_SUM;
      S_SUM:  state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wl_q        <= WL_RESET;
      widx_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        wl_q <= pwdata[WL_W-1:0];
      end
      if (cfg_wr || (in_acc && (action_i == ACT_CLEAR))) begin
        widx_q  <= '0;
        count_q <= '0;
        sum_q   <= '0;
      end else if (state_q == S_SUM) begin
        widx_q <= slot_next;
        sum_q  <= sum_d;
        if (!full) begin
          count_q <= count_q + 1'b1;
        end
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_i;
    end
    if ((state_q == S_OUT) && out_free) begin
      average_q <= quotient[SAMPLE_BITS-1:0];
    end
  end

  maf_ring_mem #(
    .DEPTH(WINDOW_MAX),
    .WIDTH(SAMPLE_BITS)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (state_q == S_SUM),
    .waddr_i(slot),
    .wdata_i(sample_q),
    .raddr_i(slot),
    .rdata_o(old_sample)
  );

  maf_divider #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_d),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;

endmodule

@@ rtl/maf_ring_mem.sv @@
module maf_ring_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/maf_divider.sv @@
module maf_divider #(
  parameter int SUM_W = 24,
  parameter int CNT_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [SUM_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  rem_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  div_q;
  logic              neg_q;

  logic [CNT_W:0]    trial;
  logic              fits;
  logic [SUM_W-1:0]  magnitude;

  // Restoring division: one quotient bit per cycle, dividend bits shift out
  // of the top of quo_q while quotient bits shift in at the bottom.
  assign trial     = {rem_q, quo_q[SUM_W-1]};
  assign fits      = trial >= {1'b0, div_q};
  assign magnitude = dividend_i[SUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(SUM_W);
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= magnitude;
      div_q <= divisor_i;
      neg_q <= dividend_i[SUM_W-1];
    end else if (busy_q) begin
      rem_q <= fits ? CNT_W'(trial - {1'b0, div_q}) : CNT_W'(trial);
      quo_q <= {quo_q[SUM_W-2:0], fits};
    end
  end

  assign done_o     = busy_q && (step_q == STEP_W'(1));
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

@@ rtl/maf_checker.sv @@
`include "assert_macros.svh"

module maf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic action_i,
  input logic out_valid_o,
  input logic out_stall_i
);

  import maf_pkg::*;

  // A held result is not dropped while the receiver stalls.
  `ASSERT_CLK(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped under stall")

  // A sample keeps the input stalled while it is averaged.
  `ASSERT_CLK(a_sample_busy, in_valid_i && !in_stall_o && (action_i == ACT_SAMPLE) |=> in_stall_o, "sample item did not start work")

  // A clear finishes at once and leaves the input open.
  `ASSERT_CLK(a_clear_quick, in_valid_i && !in_stall_o && (action_i == ACT_CLEAR) |=> !in_stall_o, "clear item left the block busy")

  // Once reset has been sampled, no result is pending and the input is open.
  `ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o && !in_stall_o, "block not idle in reset")

endmodule

bind moving_average_filter_unit maf_checker u_maf_checker (.*);

@@ dv/tb_moving_average_filter_unit.sv @@
module tb_moving_average_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WMAX = maf_pkg::WINDOW_MAX_DEF;
  localparam int SB = maf_pkg::SAMPLE_BITS_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int STUCK_LIMIT = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic action_i = maf_pkg::ACT_SAMPLE;
  logic signed [SB-1:0] sample_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [SB-1:0] average_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [maf_pkg::PADDR_W-1:0] paddr = '0;
  logic [maf_pkg::PDATA_W-1:0] pwdata = '0;
  logic [maf_pkg::PDATA_W-1:0] prdata;
  logic pready;

  // Mirror of the filter state.
  logic [maf_pkg::WL_W-1:0] win_len = maf_pkg::WL_RESET;
  logic signed [SB-1:0] ring_mem [WMAX];
  int wr_idx;
  int fill_cnt;
  int sum_acc;

  logic signed [SB-1:0] avg_q [$];
  bit gaps_on = 1'b1;
  int fail_cnt = 0;
  int stuck_cycles = 0;

  moving_average_filter_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .average_o  (average_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #1ns clk_i = 1'b1;
    #1ns clk_i = 1'b0;
  end

  function automatic void clear_window();
    foreach (ring_mem[i]) ring_mem[i] = '0;
    wr_idx = 0;
    fill_cnt = 0;
    sum_acc = 0;
  endfunction

  function automatic void predict_average(input logic act, input logic signed [SB-1:0] smp);
    int n;
    int slot;
    int mean;
    n = (win_len == 0) ? 1 : (win_len > WMAX) ? WMAX : int'(win_len);
    if (act == maf_pkg::ACT_CLEAR) begin
      clear_window();
      return;
    end
    slot = (wr_idx >= n) ? 0 : wr_idx;
    if (fill_cnt < n) begin
      ring_mem[slot] = smp;
      sum_acc += smp;
      fill_cnt++;
      mean = sum_acc / fill_cnt;
    end else begin
      sum_acc = sum_acc - ring_mem[slot] + smp;
      ring_mem[slot] = smp;
      mean = sum_acc / n;
    end
    slot++;
    wr_idx = (slot >= n) ? 0 : slot;
    avg_q.push_back(SB'(mean));
  endfunction

  // Receiver back-pressure in random bursts.
  initial begin
    forever begin
      @(posedge clk_i);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (avg_q.size() == 0) begin
        $display("%0t: unexpected average, expected none, actual %0d", $time, average_o);
        fail_cnt++;
      end else begin
        if (average_o !== avg_q[0]) begin
          $display("%0t: average mismatch, expected %0d, actual %0d",
                   $time, avg_q[0], average_o);
          fail_cnt++;
        end
        void'(avg_q.pop_front());
      end
    end
  end

  // Watchdog on cycles in which no item and no register write moves.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pwrite && pready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input logic act, input logic signed [SB-1:0] smp);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    sample_i <= smp;
    do @(posedge clk_i); while (in_stall_o);
    predict_average(act, smp);
  endtask

  task automatic send_random(input int count, input int extreme_pct);
    logic signed [SB-1:0] smp;
    logic act;
    repeat (count) begin
      act = ($urandom_range(0, 99) < 8) ? maf_pkg::ACT_CLEAR : maf_pkg::ACT_SAMPLE;
      if ($urandom_range(0, 99) < extreme_pct) begin
        smp = $urandom_range(0, 1) ? {1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}};
      end else begin
        smp = SB'($urandom);
      end
      send_item(act, smp);
    end
  endtask

  // Lets the last sample finish, since a trailing clear gives nothing to wait on.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (avg_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [maf_pkg::WL_W-1:0] len);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {maf_pkg::REG_WINDOW_LENGTH, 2'b00};
    pwdata <= maf_pkg::PDATA_W'(len);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    win_len = len;
    clear_window();
  endtask

  task automatic test_directed_extremes();
    repeat (9) send_item(maf_pkg::ACT_SAMPLE, 16'sh7fff);
    repeat (8) send_item(maf_pkg::ACT_SAMPLE, -16'sh8000);
    send_item(maf_pkg::ACT_CLEAR, 16'shffff);
    // Negative sums must truncate toward zero.
    send_item(maf_pkg::ACT_SAMPLE, -16'sd1);
    send_item(maf_pkg::ACT_SAMPLE, -16'sd2);
    send_item(maf_pkg::ACT_SAMPLE, 16'sd0);
    send_item(maf_pkg::ACT_CLEAR, 16'sd0);
    send_item(maf_pkg::ACT_SAMPLE, 16'sd1);
    send_item(maf_pkg::ACT_SAMPLE, 16'sd2);
  endtask

  task automatic test_window_lengths();
    drain_results();
    write_window(9'd1);
    send_random(30, 20);
    drain_results();
    write_window(9'd0);
    send_random(30, 20);
    drain_results();
    // Saturates to the full ring; more items than ring entries, with large sums.
    write_window(9'd511);
    send_random(280, 60);
    drain_results();
    write_window(9'd256);
    send_random(20, 50);
    drain_results();
    write_window(9'd257);
    send_random(20, 50);
    drain_results();
    write_window(9'd2);
    send_random(30, 20);
  endtask

  task automatic test_random_windows();
    repeat (5) begin
      drain_results();
      write_window(maf_pkg::WL_W'($urandom_range(3, 24)));
      send_random(40, 15);
    end
  endtask

  task automatic test_steady_stream();
    drain_results();
    gaps_on = 1'b0;
    write_window(maf_pkg::WL_RESET);
    send_random(60, 15);
  endtask

  initial begin
    clear_window();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_window_lengths();
    test_random_windows();
    test_steady_stream();
    drain_results();
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
